@@ rtl/core/tli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg: shared definitions for the tape language interpreter
// Sizes, item opcodes, status codes, command characters and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

  // Store sizes and the address widths derived from them.
  localparam int unsigned PROGRAM_BYTES = 4096;
  localparam int unsigned TAPE_CELLS    = 32768;
  localparam int unsigned PROG_AW       = $clog2(PROGRAM_BYTES);
  localparam int unsigned TAPE_AW       = $clog2(TAPE_CELLS);
  localparam int unsigned PC_W          = 13;
  localparam int unsigned CLR_DEPTH     = (PROGRAM_BYTES > TAPE_CELLS) ? PROGRAM_BYTES
                                                                      : TAPE_CELLS;
  localparam int unsigned CLR_W         = $clog2(CLR_DEPTH);

  // Item opcodes.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Run status codes.
  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;

  // Command characters.
  localparam logic [7:0] CHR_INC   = 8'h2B;
  localparam logic [7:0] CHR_DEC   = 8'h2D;
  localparam logic [7:0] CHR_RIGHT = 8'h3E;
  localparam logic [7:0] CHR_LEFT  = 8'h3C;
  localparam logic [7:0] CHR_OUT   = 8'h2E;
  localparam logic [7:0] CHR_IN    = 8'h2C;
  localparam logic [7:0] CHR_OPEN  = 8'h5B;
  localparam logic [7:0] CHR_CLOSE = 8'h5D;

  // Classes of a program byte.
  localparam logic [3:0] CLS_OTHER = 4'd0;
  localparam logic [3:0] CLS_ZERO  = 4'd1;
  localparam logic [3:0] CLS_INC   = 4'd2;
  localparam logic [3:0] CLS_DEC   = 4'd3;
  localparam logic [3:0] CLS_RIGHT = 4'd4;
  localparam logic [3:0] CLS_LEFT  = 4'd5;
  localparam logic [3:0] CLS_OUT   = 4'd6;
  localparam logic [3:0] CLS_IN    = 4'd7;
  localparam logic [3:0] CLS_OPEN  = 4'd8;
  localparam logic [3:0] CLS_CLOSE = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;          // capture the accepted item
    logic clr_write;      // clearing sweep writes zero and advances
    logic prog_write;     // write the load byte into the program store
    logic read_exec;      // read program byte at the counter and the current cell
    logic tape_inc;
    logic tape_dec;
    logic tape_in;
    logic cell_fwd;
    logic cell_back;
    logic emit;
    logic take;
    logic pc_inc;
    logic pc_clear;
    logic pc_from_scan;   // counter lands just past the matching bracket
    logic halt_clear;
    logic halt_end;
    logic halt_unmatched;
    logic scan_init;
    logic scan_fwd;       // step the scan position up and read there
    logic scan_bwd;       // step the scan position down and read there
    logic depth_up;
    logic depth_down;
    logic out_load;
  } tli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] opcode;
    logic       halted;
    logic       pc_past_end;
    logic [3:0] cls;
    logic       cell_zero;
    logic       scan_fwd_limit;
    logic       scan_at_zero;
    logic       depth_one;
    logic       out_free;
    logic       clr_last;
  } tli_stat_t;

  // Sorts a program byte into its command class.
  function automatic logic [3:0] char_class(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      8'h00:     r = CLS_ZERO;
      CHR_INC:   r = CLS_INC;
      CHR_DEC:   r = CLS_DEC;
      CHR_RIGHT: r = CLS_RIGHT;
      CHR_LEFT:  r = CLS_LEFT;
      CHR_OUT:   r = CLS_OUT;
      CHR_IN:    r = CLS_IN;
      CHR_OPEN:  r = CLS_OPEN;
      CHR_CLOSE: r = CLS_CLOSE;
      default:   r = CLS_OTHER;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/tli_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_if: item channels of the tape language interpreter
// The command channel carries items in, the response channel carries one
// result per item out. A transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface tli_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] load_address;
  logic [7:0]  load_byte;
  logic [7:0]  input_byte;

  modport source (output valid, output opcode, output load_address,
                  output load_byte, output input_byte, input ready);
  modport sink   (input valid, input opcode, input load_address,
                  input load_byte, input input_byte, output ready);
endinterface

interface tli_rsp_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        input_taken;
  logic [1:0]  status;
  logic [12:0] program_position;

  modport source (output valid, output out_valid, output out_byte, output input_taken,
                  output status, output program_position, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input input_taken,
                  input status, input program_position, output ready);
endinterface

@@ rtl/core/tape_language_interpreter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_language_interpreter: eight-command tape language interpreter
// After reset the block clears its program store and tape in a sweep over
// the 32768 addresses of the larger memory (one entry of each memory per
// cycle) and accepts no item until the sweep ends. It then takes one item at
// a time and returns one result per item through an output register, so the
// next item is accepted while a result still waits. Every item passes decode
// and the result hand-off; an executed command adds a registered read of the
// program store and tape, then the read-modify-write of the cell. A bracket
// jump reads the scanned program bytes one at a time through the single read
// port of the program store. Status codes: 0 running, 1 program ended, 2
// unmatched bracket.
// ----------------------------------------------------------------------------
module tape_language_interpreter (
  input  logic    clk,
  input  logic    rst,
  tli_cmd_if.sink   cmd,
  tli_rsp_if.source rsp
);

  tli_pkg::tli_cmd_t  dp_cmd;
  tli_pkg::tli_stat_t dp_stat;

  // Sequencer.
  tli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .cmd      (dp_cmd),
    .stat     (dp_stat)
  );

  // Stores, state registers and result register.
  tli_datapath u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (dp_cmd),
    .stat                 (dp_stat),
    .opcode               (cmd.opcode),
    .load_address         (cmd.load_address),
    .load_byte            (cmd.load_byte),
    .input_byte           (cmd.input_byte),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_out_valid        (rsp.out_valid),
    .rsp_out_byte         (rsp.out_byte),
    .rsp_input_taken      (rsp.input_taken),
    .rsp_status           (rsp.status),
    .rsp_program_position (rsp.program_position)
  );

endmodule

@@ rtl/core/tli_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tli_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_datapath: stores, registers and arithmetic of the interpreter
// Holds the program store, the tape, the cell index, the program counter,
// the halt code, the bracket scan position and depth, and the result register.
// ----------------------------------------------------------------------------
module tli_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tli_pkg::tli_cmd_t cmd,
  output tli_pkg::tli_stat_t stat,
  input  logic [1:0]        opcode,
  input  logic [11:0]       load_address,
  input  logic [7:0]        load_byte,
  input  logic [7:0]        input_byte,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              rsp_out_valid,
  output logic [7:0]        rsp_out_byte,
  output logic              rsp_input_taken,
  output logic [1:0]        rsp_status,
  output logic [12:0]       rsp_program_position
);

  // Captured item.
  logic [1:0]                 opcode_q;
  logic [11:0]                load_addr_q;
  logic [7:0]                 load_byte_q;
  logic [7:0]                 input_byte_q;

  // Architectural state.
  logic [tli_pkg::TAPE_AW-1:0] cell_index;
  logic [tli_pkg::PC_W-1:0]    pc;
  logic [1:0]                  halted;

  // Bracket scan state.
  logic [tli_pkg::PC_W-1:0]    scan_pos;
  logic [tli_pkg::PC_W-1:0]    scan_pos_inc;
  logic [tli_pkg::PC_W-1:0]    scan_pos_dec;
  logic [tli_pkg::PC_W-1:0]    depth;

  // Clearing sweep address.
  logic [tli_pkg::CLR_W-1:0]   clr_addr;

  // Per-item result flags.
  logic                        res_emit;
  logic [7:0]                  res_byte;
  logic                        res_take;
  logic                        out_full;

  // Memory ports.
  logic                        prog_we;
  logic [tli_pkg::PROG_AW-1:0] prog_waddr;
  logic [7:0]                  prog_wdata;
  logic [tli_pkg::PROG_AW-1:0] prog_raddr;
  logic [7:0]                  prog_rdata;
  logic                        tape_we;
  logic [tli_pkg::TAPE_AW-1:0] tape_waddr;
  logic [7:0]                  tape_wdata;
  logic [7:0]                  tape_rdata;

  assign scan_pos_inc = scan_pos + tli_pkg::PC_W'(1);
  assign scan_pos_dec = scan_pos - tli_pkg::PC_W'(1);

  // Program store ports: sweep or load on the write side, counter or scan on read.
  assign prog_we    = cmd.clr_write | cmd.prog_write;
  assign prog_waddr = cmd.clr_write ? tli_pkg::PROG_AW'(clr_addr)
                                    : tli_pkg::PROG_AW'(load_addr_q);
  assign prog_wdata = cmd.clr_write ? 8'd0 : load_byte_q;

  always_comb begin
    if (cmd.scan_fwd) begin
      prog_raddr = tli_pkg::PROG_AW'(scan_pos_inc);
    end else if (cmd.scan_bwd) begin
      prog_raddr = tli_pkg::PROG_AW'(scan_pos_dec);
    end else begin
      prog_raddr = tli_pkg::PROG_AW'(pc);
    end
  end

  // Tape ports: the current cell is read and rewritten.
  assign tape_we    = cmd.clr_write | cmd.tape_inc | cmd.tape_dec | cmd.tape_in;
  assign tape_waddr = cmd.clr_write ? tli_pkg::TAPE_AW'(clr_addr) : cell_index;

  always_comb begin
    if (cmd.clr_write) begin
      tape_wdata = 8'd0;
    end else if (cmd.tape_inc) begin
      tape_wdata = tape_rdata + 8'd1;
    end else if (cmd.tape_dec) begin
      tape_wdata = tape_rdata - 8'd1;
    end else begin
      tape_wdata = input_byte_q;
    end
  end

  tli_ram #(
    .WIDTH (8),
    .DEPTH (tli_pkg::PROGRAM_BYTES)
  ) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_waddr),
    .wdata (prog_wdata),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  tli_ram #(
    .WIDTH (8),
    .DEPTH (tli_pkg::TAPE_CELLS)
  ) u_tape_ram (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (cell_index),
    .rdata (tape_rdata)
  );

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      opcode_q     <= opcode;
      load_addr_q  <= load_address;
      load_byte_q  <= load_byte;
      input_byte_q <= input_byte;
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + tli_pkg::CLR_W'(1);
    end
  end

  // Cell index with wrap at the tape size.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_index <= '0;
    end else if (cmd.cell_fwd) begin
      if (cell_index == tli_pkg::TAPE_AW'(tli_pkg::TAPE_CELLS - 1)) begin
        cell_index <= '0;
      end else begin
        cell_index <= cell_index + tli_pkg::TAPE_AW'(1);
      end
    end else if (cmd.cell_back) begin
      if (cell_index == '0) begin
        cell_index <= tli_pkg::TAPE_AW'(tli_pkg::TAPE_CELLS - 1);
      end else begin
        cell_index <= cell_index - tli_pkg::TAPE_AW'(1);
      end
    end
  end

  // Program counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (cmd.pc_clear) begin
      pc <= '0;
    end else if (cmd.pc_from_scan) begin
      pc <= scan_pos + tli_pkg::PC_W'(1);
    end else if (cmd.pc_inc) begin
      pc <= pc + tli_pkg::PC_W'(1);
    end
  end

  // Halt code.
  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= tli_pkg::ST_RUN;
    end else if (cmd.halt_clear) begin
      halted <= tli_pkg::ST_RUN;
    end else if (cmd.halt_end) begin
      halted <= tli_pkg::ST_END;
    end else if (cmd.halt_unmatched) begin
      halted <= tli_pkg::ST_UNMATCHED;
    end
  end

  // Bracket scan position and nesting depth.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_pos <= pc;
      depth    <= tli_pkg::PC_W'(1);
    end else begin
      if (cmd.scan_fwd) begin
        scan_pos <= scan_pos_inc;
      end else if (cmd.scan_bwd) begin
        scan_pos <= scan_pos_dec;
      end
      if (cmd.depth_up) begin
        depth <= depth + tli_pkg::PC_W'(1);
      end else if (cmd.depth_down) begin
        depth <= depth - tli_pkg::PC_W'(1);
      end
    end
  end

  // Per-item result flags, cleared when an item is captured.
  always_ff @(posedge clk) begin
    if (rst || cmd.latch) begin
      res_emit <= 1'b0;
      res_byte <= 8'd0;
      res_take <= 1'b0;
    end else begin
      if (cmd.emit) begin
        res_emit <= 1'b1;
        res_byte <= tape_rdata;
      end
      if (cmd.take) begin
        res_take <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (rsp_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_out_valid        <= res_emit;
      rsp_out_byte         <= res_byte;
      rsp_input_taken      <= res_take;
      rsp_status           <= halted;
      rsp_program_position <= 13'(pc);
    end
  end

  assign rsp_valid = out_full;

  // Status toward the controller.
  always_comb begin
    stat.opcode         = opcode_q;
    stat.halted         = (halted != tli_pkg::ST_RUN);
    stat.pc_past_end    = (pc >= tli_pkg::PC_W'(tli_pkg::PROGRAM_BYTES));
    stat.cls            = tli_pkg::char_class(prog_rdata);
    stat.cell_zero      = (tape_rdata == 8'd0);
    stat.scan_fwd_limit = (scan_pos >= tli_pkg::PC_W'(tli_pkg::PROGRAM_BYTES - 1));
    stat.scan_at_zero   = (scan_pos == '0);
    stat.depth_one      = (depth == tli_pkg::PC_W'(1));
    stat.out_free       = ~out_full;
    stat.clr_last       = (clr_addr == tli_pkg::CLR_W'(tli_pkg::CLR_DEPTH - 1));
  end

endmodule

@@ rtl/core/tli_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_ctrl: sequencer of the tape language interpreter
// Runs the clearing sweep after reset, then takes one item at a time through
// decode, command execution, bracket scans and the result hand-off.
// ----------------------------------------------------------------------------
module tli_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output tli_pkg::tli_cmd_t  cmd,
  input  tli_pkg::tli_stat_t stat
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DECODE    = 4'd2;
  localparam logic [3:0] S_EXEC      = 4'd3;
  localparam logic [3:0] S_FWD_ISSUE = 4'd4;
  localparam logic [3:0] S_FWD_CHECK = 4'd5;
  localparam logic [3:0] S_BWD_ISSUE = 4'd6;
  localparam logic [3:0] S_BWD_CHECK = 4'd7;
  localparam logic [3:0] S_RESULT    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_RESULT;
        unique case (stat.opcode)
          tli_pkg::OP_LOAD: begin
            cmd.prog_write = 1'b1;
          end
          tli_pkg::OP_START: begin
            cmd.pc_clear   = 1'b1;
            cmd.halt_clear = 1'b1;
          end
          tli_pkg::OP_STEP: begin
            if (!stat.halted) begin
              if (stat.pc_past_end) begin
                cmd.halt_end = 1'b1;
              end else begin
                cmd.read_exec = 1'b1;
                state_next    = S_EXEC;
              end
            end
          end
          default: begin
            state_next = S_RESULT;
          end
        endcase
      end
      S_EXEC: begin
        state_next = S_RESULT;
        unique case (stat.cls)
          tli_pkg::CLS_ZERO: begin
            cmd.halt_end = 1'b1;
          end
          tli_pkg::CLS_INC: begin
            cmd.tape_inc = 1'b1;
            cmd.pc_inc   = 1'b1;
          end
          tli_pkg::CLS_DEC: begin
            cmd.tape_dec = 1'b1;
            cmd.pc_inc   = 1'b1;
          end
          tli_pkg::CLS_RIGHT: begin
            cmd.cell_fwd = 1'b1;
            cmd.pc_inc   = 1'b1;
          end
          tli_pkg::CLS_LEFT: begin
            cmd.cell_back = 1'b1;
            cmd.pc_inc    = 1'b1;
          end
          tli_pkg::CLS_OUT: begin
            cmd.emit   = 1'b1;
            cmd.pc_inc = 1'b1;
          end
          tli_pkg::CLS_IN: begin
            cmd.tape_in = 1'b1;
            cmd.take    = 1'b1;
            cmd.pc_inc  = 1'b1;
          end
          tli_pkg::CLS_OPEN: begin
            if (stat.cell_zero) begin
              cmd.scan_init = 1'b1;
              state_next    = S_FWD_ISSUE;
            end else begin
              cmd.pc_inc = 1'b1;
            end
          end
          tli_pkg::CLS_CLOSE: begin
            if (stat.cell_zero) begin
              cmd.pc_inc = 1'b1;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_BWD_ISSUE;
            end
          end
          default: begin
            cmd.pc_inc = 1'b1;
          end
        endcase
      end
      // Forward scan: step up one byte and read it.
      S_FWD_ISSUE: begin
        if (stat.scan_fwd_limit) begin
          cmd.halt_unmatched = 1'b1;
          state_next         = S_RESULT;
        end else begin
          cmd.scan_fwd = 1'b1;
          state_next   = S_FWD_CHECK;
        end
      end
      S_FWD_CHECK: begin
        state_next = S_FWD_ISSUE;
        case (stat.cls)
          tli_pkg::CLS_ZERO: begin
            cmd.halt_unmatched = 1'b1;
            state_next         = S_RESULT;
          end
          tli_pkg::CLS_OPEN: begin
            cmd.depth_up = 1'b1;
          end
          tli_pkg::CLS_CLOSE: begin
            if (stat.depth_one) begin
              cmd.pc_from_scan = 1'b1;
              state_next       = S_RESULT;
            end else begin
              cmd.depth_down = 1'b1;
            end
          end
          default: begin
            state_next = S_FWD_ISSUE;
          end
        endcase
      end
      // Backward scan: step down one byte and read it.
      S_BWD_ISSUE: begin
        if (stat.scan_at_zero) begin
          cmd.halt_unmatched = 1'b1;
          state_next         = S_RESULT;
        end else begin
          cmd.scan_bwd = 1'b1;
          state_next   = S_BWD_CHECK;
        end
      end
      S_BWD_CHECK: begin
        state_next = S_BWD_ISSUE;
        case (stat.cls)
          tli_pkg::CLS_CLOSE: begin
            cmd.depth_up = 1'b1;
          end
          tli_pkg::CLS_OPEN: begin
            if (stat.depth_one) begin
              cmd.pc_from_scan = 1'b1;
              state_next       = S_RESULT;
            end else begin
              cmd.depth_down = 1'b1;
            end
          end
          default: begin
            state_next = S_BWD_ISSUE;
          end
        endcase
      end
      // Hand the result to the output register once it is free.
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ tb/tli_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_result_checker: result predictor and comparator for the interpreter
// Watches both item channels. Every command transfer is run through a local
// model of the program store, the tape and the run state, and the expected
// result is queued. Every response transfer is compared field by field with
// the oldest queued result.
// ----------------------------------------------------------------------------
module tli_result_checker (
  input  logic clk,
  input  logic rst,
  tli_cmd_if   cmd,
  tli_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);
  import tli_pkg::*;

  typedef struct packed {
    logic            emitted;
    logic [7:0]      emitted_byte;
    logic            consumed;
    logic [1:0]      run_status;
    logic [PC_W-1:0] position;
  } step_result_t;

  logic [7:0]         program_mem [PROGRAM_BYTES];
  logic [7:0]         tape_mem [TAPE_CELLS];
  logic [TAPE_AW-1:0] cell_ptr;
  logic [PC_W-1:0]    pc;
  logic [1:0]         run_state;
  step_result_t       expected_q [$];
  int                 fail_count;

  assign mismatches = fail_count;

  // Forward scan for the matching close bracket; the counter lands on it.
  function automatic void jump_forward();
    int pos;
    int depth;
    pos = int'(pc);
    depth = 1;
    while (depth != 0 && run_state == ST_RUN) begin
      pos++;
      if (pos >= int'(PROGRAM_BYTES) || program_mem[pos] == 8'h00) begin
        run_state = ST_UNMATCHED;
      end else if (program_mem[pos] == CHR_OPEN) begin
        depth++;
      end else if (program_mem[pos] == CHR_CLOSE) begin
        depth--;
      end
    end
    if (run_state == ST_RUN) pc = pos[PC_W-1:0];
  endfunction

  // Backward scan for the matching open bracket; running off address zero halts.
  function automatic void jump_back();
    int pos;
    int depth;
    pos = int'(pc);
    depth = 1;
    while (depth != 0 && run_state == ST_RUN) begin
      if (pos == 0) begin
        run_state = ST_UNMATCHED;
      end else begin
        pos--;
        if (program_mem[pos] == CHR_CLOSE) depth++;
        else if (program_mem[pos] == CHR_OPEN) depth--;
      end
    end
    if (run_state == ST_RUN) pc = pos[PC_W-1:0];
  endfunction

  // Applies one accepted item to the local state and returns its result.
  function automatic step_result_t apply_item(input logic [1:0] op, input logic [11:0] addr,
                                              input logic [7:0] lbyte,
                                              input logic [7:0] ibyte);
    step_result_t r;
    logic [7:0]   c;
    r = '0;
    case (op)
      OP_LOAD: begin
        program_mem[int'(addr) % PROGRAM_BYTES] = lbyte;
      end
      OP_START: begin
        pc = '0;
        run_state = ST_RUN;
      end
      OP_STEP: begin
        if (run_state == ST_RUN) begin
          if (int'(pc) >= int'(PROGRAM_BYTES) || program_mem[int'(pc)] == 8'h00) begin
            run_state = ST_END;
          end else begin
            c = program_mem[int'(pc)];
            case (c)
              CHR_INC:   tape_mem[cell_ptr] = tape_mem[cell_ptr] + 8'd1;
              CHR_DEC:   tape_mem[cell_ptr] = tape_mem[cell_ptr] - 8'd1;
              CHR_RIGHT: begin
                if (int'(cell_ptr) == int'(TAPE_CELLS) - 1) cell_ptr = '0;
                else cell_ptr = cell_ptr + 1'b1;
              end
              CHR_LEFT: begin
                if (cell_ptr == '0) cell_ptr = TAPE_AW'(TAPE_CELLS - 1);
                else cell_ptr = cell_ptr - 1'b1;
              end
              CHR_OUT: begin
                r.emitted = 1'b1;
                r.emitted_byte = tape_mem[cell_ptr];
              end
              CHR_IN: begin
                r.consumed = 1'b1;
                tape_mem[cell_ptr] = ibyte;
              end
              CHR_OPEN:  if (tape_mem[cell_ptr] == 8'h00) jump_forward();
              CHR_CLOSE: if (tape_mem[cell_ptr] != 8'h00) jump_back();
              default: ;
            endcase
            if (run_state == ST_RUN) pc = pc + 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.run_status = run_state;
    r.position = pc;
    return r;
  endfunction

  // Responses are checked before the command of the same edge is predicted,
  // since no result can belong to an item accepted at that edge.
  always @(posedge clk) begin
    step_result_t want;
    step_result_t got;
    if (rst) begin
      for (int i = 0; i < int'(PROGRAM_BYTES); i++) program_mem[i] = 8'h00;
      for (int i = 0; i < int'(TAPE_CELLS); i++) tape_mem[i] = 8'h00;
      cell_ptr = '0;
      pc = '0;
      run_state = ST_RUN;
      expected_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.out_valid, rsp.out_byte, rsp.input_taken, rsp.status,
               rsp.program_position};
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response transfer with no result pending", $realtime);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: result mismatch: expected out_valid=%0b out_byte=%02h ",
                        "input_taken=%0b status=%0d position=%0d, got out_valid=%0b ",
                        "out_byte=%02h input_taken=%0b status=%0d position=%0d"},
                       $realtime, want.emitted, want.emitted_byte, want.consumed,
                       want.run_status, want.position, got.emitted, got.emitted_byte,
                       got.consumed, got.run_status, got.position);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        expected_q.push_back(apply_item(cmd.opcode, cmd.load_address, cmd.load_byte,
                                        cmd.input_byte));
      pending <= expected_q.size();
    end
  end

endmodule

@@ tb/tape_language_interpreter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_language_interpreter_tb: top level of the interpreter testbench
// Drives a directed program over the command and tape extremes, then many
// short random programs with stray loads, starts and unused opcodes mixed
// into the steps. Both channels idle at random; the response side also holds
// off once for a long stretch. The checker instance predicts and compares
// every result.
// ----------------------------------------------------------------------------
module tape_language_interpreter_tb;
  import tli_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 100000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         RANDOM_ITEMS   = 760;
  localparam int         STEADY_ITEMS   = 200;
  localparam int         HOLD_AT_ITEM   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;
  bit   hold_req = 1'b0;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  int   mismatches;
  int   pending;

  tli_cmd_if cmd_ch ();
  tli_rsp_if rsp_ch ();

  tape_language_interpreter dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  tli_result_checker result_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // Offers one item after a random gap and returns at the edge of its transfer.
  task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                           input logic [7:0] lbyte, input logic [7:0] ibyte);
    while (!steady && $urandom_range(99) < 36) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= op;
    cmd_ch.load_address <= addr;
    cmd_ch.load_byte    <= lbyte;
    cmd_ch.input_byte   <= ibyte;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
  endtask

  task automatic load_program_byte(input logic [11:0] addr, input logic [7:0] value);
    send_item(OP_LOAD, addr, value, 8'($urandom));
  endtask

  task automatic step_once(input logic [7:0] ibyte);
    send_item(OP_STEP, 12'($urandom), 8'($urandom), ibyte);
  endtask

  task automatic start_run();
    send_item(OP_START, 12'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stops offering items until every result has come back.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Loads a short random program, starts it and steps through it. Most
  // programs have balanced brackets; some are left unbalanced on purpose.
  task automatic run_random_program();
    logic [7:0] body [$];
    logic [7:0] c;
    int         len;
    int         opens;
    int         steps;
    int         r;
    bit         sloppy;
    len = $urandom_range(1, 20);
    sloppy = ($urandom_range(7) == 0);
    opens = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 14) c = CHR_INC;
      else if (r < 26) c = CHR_DEC;
      else if (r < 36) c = CHR_RIGHT;
      else if (r < 46) c = CHR_LEFT;
      else if (r < 56) c = CHR_OUT;
      else if (r < 64) c = CHR_IN;
      else if (r < 78) c = CHR_OPEN;
      else if (r < 90) c = CHR_CLOSE;
      else c = 8'($urandom_range(1, 255));
      if (!sloppy) begin
        if (c == CHR_OPEN) begin
          opens++;
        end else if (c == CHR_CLOSE) begin
          if (opens == 0) c = CHR_DEC;
          else opens--;
        end
      end
      body.push_back(c);
    end
    while (!sloppy && opens > 0) begin
      body.push_back(CHR_CLOSE);
      opens--;
    end
    foreach (body[i]) load_program_byte(12'(i), body[i]);
    load_program_byte(12'(body.size()), 8'h00);
    start_run();
    steps = $urandom_range(body.size(), 4 * body.size() + 8);
    // Stray items land in the middle of the run.
    repeat (steps) begin
      r = $urandom_range(99);
      if (r < 3) send_item(OP_UNUSED, 12'($urandom), 8'($urandom), 8'($urandom));
      else if (r < 7) load_program_byte(12'($urandom), 8'($urandom));
      else if (r < 9) start_run();
      else step_once(8'($urandom));
    end
  endtask

  initial begin
    int         base;
    bit         hold_done;
    cmd_ch.valid        = 1'b0;
    cmd_ch.opcode       = OP_LOAD;
    cmd_ch.load_address = '0;
    cmd_ch.load_byte    = '0;
    cmd_ch.input_byte   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed program: cell index wraps both ways, cell value wraps both
    // ways, output, input, a skipped loop, a plain byte, then the program end.
    load_program_byte(12'd0, CHR_LEFT);
    load_program_byte(12'd1, CHR_IN);
    load_program_byte(12'd2, CHR_INC);
    load_program_byte(12'd3, CHR_DEC);
    load_program_byte(12'd4, CHR_OUT);
    load_program_byte(12'd5, CHR_RIGHT);
    load_program_byte(12'd6, CHR_OPEN);
    load_program_byte(12'd7, CHR_INC);
    load_program_byte(12'd8, CHR_CLOSE);
    load_program_byte(12'd9, 8'h41);
    load_program_byte(12'hFFF, 8'hFF);
    send_item(OP_UNUSED, 12'hFFF, 8'hFF, 8'hFF);
    start_run();
    step_once(8'h00);
    step_once(8'hFF);
    // The last two steps hit the program end and then repeat the halt.
    repeat (8) step_once(8'h00);
    wait_drained();

    // Random programs, the first part with no idling on either side.
    steady = 1'b1;
    hold_done = 1'b0;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (items_sent - base >= STEADY_ITEMS) steady = 1'b0;
      if (!hold_done && items_sent - base >= HOLD_AT_ITEM) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      run_random_program();
      if ($urandom_range(9) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ tape_language_interpreter.f @@
rtl/core/tli_pkg.sv
rtl/core/tli_if.sv
rtl/core/tli_ram.sv
rtl/core/tli_datapath.sv
rtl/core/tli_ctrl.sv
rtl/core/tape_language_interpreter.sv
tb/tli_result_checker.sv
tb/tape_language_interpreter_tb.sv
